/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker of the sorted request queue.
// Needs no other file; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define SRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication that must hold whenever the result beat is offered.
`define SRQ_ASSERT_OUT(label, prop, msg) \
  `SRQ_ASSERT(label, m_axis_tvalid_o |-> (prop), msg)

`endif

/* rtl/srq_pkg.sv */
// Package of the sorted request queue: operation, status and FSM codes.
// No dependencies; used by the top level and its checker.
`default_nettype none

package srq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_FIND   = 2'd3
  } srq_op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } srq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } srq_state_e;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 16;

endpackage

`default_nettype wire

/* rtl/srq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module srq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/sorted_request_queue_top.sv */
// Sorted request queue: entries of (priority, process id) kept in ascending
// order (ties to the lower id, equal pairs after existing ones) in one RAM.
// Each input beat carries one operation in tuser (insert, remove by id, pop
// first N, find by id) and yields exactly one result beat with status,
// position and occupancy. One operation is in flight at a time; it walks the
// RAM one entry per cycle through its single read and single write port,
// shifting entries as it goes for insert, remove and pop. An operation walks
// L entries of a queue of L, L - N for a pop of N and fewer for an insert
// that finds its slot early, at most CAPACITY; a full insert walks none. A
// result waits while an earlier result beat is stalled in the output
// register. The next request can be accepted in the same cycle that the
// result is in the output register. Depends on srq_pkg, srq_ram.
`default_nettype none

module sorted_request_queue_top
  import srq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ID_BITS  = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [7:0] process_id, [39:8] priority_req, [46:40] pop_count, [47] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  wire logic [1:0]             s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [1:0] status, [7:2] position, [14:8] occupancy, [15] zero
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = 32 + ID_BITS;
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  srq_state_e state_q, state_d;
  srq_op_e    op_q, op_d, op_in;
  srq_status_e stat_q, stat_d;
  logic [ID_BITS-1:0] id_q, id_d, id_in;
  logic [31:0]   prio_q, prio_d;
  logic [CW-1:0] n_q, n_d, n_in;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] paddr_q, paddr_d;
  logic          pend_q, pend_d;
  logic          found_q, found_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic          ram_we, ram_re;
  logic [CW-1:0] wa;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [31:0]   e_prio;
  logic [ID_BITS-1:0] e_id;
  logic          new_first;
  logic [31:0]   pos_wide, len_wide;

  assign op_in = srq_op_e'(s_axis_tuser_i);
  assign id_in = ID_BITS'(s_axis_tdata_i[7:0]);
  assign n_in  = (32'(s_axis_tdata_i[46:40]) > 32'(len_q)) ? len_q
                                                           : CW'(s_axis_tdata_i[46:40]);

  assign e_prio    = ram_rdata[EW-1:ID_BITS];
  assign e_id      = ram_rdata[ID_BITS-1:0];
  assign new_first = (prio_q < e_prio) || ((prio_q == e_prio) && (id_q < e_id));

  assign pos_wide = 32'(pos_q);
  assign len_wide = 32'(len_q);

  srq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wa[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    prio_q   <= prio_d;
    n_q      <= n_d;
    rd_ptr_q <= rd_ptr_d;
    rem_q    <= rem_d;
    paddr_q  <= paddr_d;
    found_q  <= found_d;
    stat_q   <= stat_d;
    pos_q    <= pos_d;
    m_data_q <= m_data_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    prio_d    = prio_q;
    n_d       = n_q;
    len_d     = len_q;
    rd_ptr_d  = rd_ptr_q;
    rem_d     = rem_q;
    paddr_d   = paddr_q;
    pend_d    = 1'b0;
    found_d   = found_q;
    stat_d    = stat_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    wa        = '0;
    ram_raddr = '0;
    ram_wdata = ram_rdata;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = op_in;
          id_d    = id_in;
          prio_d  = s_axis_tdata_i[39:8];
          n_d     = n_in;
          found_d = 1'b0;
          stat_d  = STAT_OK;
          pos_d   = '0;
          state_d = S_WALK;
          case (op_in)
            OP_INSERT: begin
              rem_d    = len_q;
              rd_ptr_d = len_q - ONE_C;
              if (len_q == CAP_C) begin
                stat_d  = STAT_FULL;
                state_d = S_DONE;
              end
            end
            OP_POP: begin
              rem_d    = len_q - n_in;
              rd_ptr_d = n_in;
            end
            default: begin
              rem_d    = len_q;
              rd_ptr_d = '0;
            end
          endcase
        end
      end

      S_WALK: begin
        // read issue, one entry a cycle
        if (rem_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = rd_ptr_q[AW-1:0];
          pend_d    = 1'b1;
          paddr_d   = rd_ptr_q;
          rem_d     = rem_q - ONE_C;
          rd_ptr_d  = (op_q == OP_INSERT) ? rd_ptr_q - ONE_C : rd_ptr_q + ONE_C;
        end
        if (pend_q) begin
          case (op_q)
            OP_INSERT: begin
              ram_we = 1'b1;
              wa     = paddr_q + ONE_C;
              if (!new_first) begin
                ram_wdata = {prio_q, id_q};
                pos_d     = wa[AW-1:0];
                len_d     = len_q + ONE_C;
                state_d   = S_DONE;
              end
            end
            OP_POP: begin
              ram_we = 1'b1;
              wa     = paddr_q - n_q;
            end
            default: begin
              if (found_q) begin
                ram_we = (op_q == OP_REMOVE);
                wa     = paddr_q - ONE_C;
              end else if (e_id == id_q) begin
                found_d = 1'b1;
                pos_d   = paddr_q[AW-1:0];
              end
            end
          endcase
        end else if (rem_q == '0) begin
          state_d = S_DONE;
          case (op_q)
            OP_INSERT: begin
              ram_we    = 1'b1;
              wa        = '0;
              ram_wdata = {prio_q, id_q};
              pos_d     = '0;
              len_d     = len_q + ONE_C;
            end
            OP_POP: begin
              len_d = len_q - n_q;
            end
            OP_REMOVE: begin
              if (found_q) begin
                len_d = len_q - ONE_C;
              end else begin
                stat_d = STAT_NOT_FOUND;
              end
            end
            default: begin
              if (!found_q) begin
                stat_d = STAT_NOT_FOUND;
              end
            end
          endcase
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, len_wide[6:0], pos_wide[5:0], stat_q};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

/* rtl/srq_checker.sv */
// Port-level checker for the sorted request queue, bound to the top level.
// Depends on srq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srq_port_props
  import srq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [6:0] cap_field;
  logic       in_beat;

  assign cap_field = 7'(CAPACITY);
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;

  `SRQ_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result beat changed while stalled")
  `SRQ_ASSERT(a_one_in_flight, in_beat |=> !s_axis_tready_o, "request taken while one is in flight")
  `SRQ_ASSERT_OUT(a_fail_pos, m_axis_tdata_o[1:0] == STAT_OK || m_axis_tdata_o[7:2] == 6'd0, "failed operation reports a position")
  `SRQ_ASSERT_OUT(a_full_occ, m_axis_tdata_o[1:0] != STAT_FULL || m_axis_tdata_o[14:8] == cap_field, "full status with queue not full")
  `SRQ_ASSERT_OUT(a_occ_range, CAPACITY > 127 || m_axis_tdata_o[14:8] <= cap_field, "occupancy above capacity")

endmodule

bind sorted_request_queue_top srq_port_props #(
  .CAPACITY(CAPACITY)
) u_srq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire

/* verif/srq_checker.sv */
// Result checker for the sorted request queue: watches both stream channels,
// keeps its own sorted copy of the queue and compares every result beat.
// Depends on srq_pkg for the operation and status codes.
`default_nettype none

module srq_checker
  import srq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  wire logic [1:0]             s_tuser_i,
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                          mismatches_o,
  output int                          outstanding_o,
  output int                          full_rejects_o
);

  typedef struct packed {
    logic [31:0] prio;
    logic [7:0]  pid;
  } slot_t;

  typedef struct packed {
    srq_status_e status;
    logic [5:0]  pos;
    logic [6:0]  occ;
  } outcome_t;

  slot_t       slots [CAPACITY];
  int unsigned depth;
  outcome_t    awaited_outcomes [$];
  int          mismatches;
  int          results_seen;
  int          full_rejects;

  function automatic bit ahead_of(input logic [31:0] prio, input logic [7:0] pid,
                                  input slot_t other);
    return (prio < other.prio) || (prio == other.prio && pid < other.pid);
  endfunction

  function automatic int unsigned first_with_id(input logic [7:0] pid);
    int unsigned at;
    at = 0;
    while (at < depth && slots[at].pid != pid) at++;
    return at;
  endfunction

  // Applies one request to the local queue copy and returns its outcome.
  function automatic outcome_t apply_request(input srq_op_e op, input logic [7:0] pid,
                                             input logic [31:0] prio,
                                             input logic [6:0] cnt);
    outcome_t    r;
    int unsigned at;
    int unsigned k;
    int unsigned take;
    r.status = STAT_OK;
    r.pos    = '0;
    case (op)
      OP_INSERT: begin
        if (depth >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          at = 0;
          while (at < depth && !ahead_of(prio, pid, slots[at])) at++;
          for (k = depth; k > at; k--) slots[k] = slots[k - 1];
          slots[at] = '{prio: prio, pid: pid};
          depth++;
          r.pos = at[5:0];
        end
      end
      OP_REMOVE: begin
        at = first_with_id(pid);
        if (at >= depth) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.pos = at[5:0];
          for (k = at; k + 1 < depth; k++) slots[k] = slots[k + 1];
          depth--;
        end
      end
      OP_POP: begin
        take = (cnt > depth) ? depth : cnt;
        for (k = 0; k + take < depth; k++) slots[k] = slots[k + take];
        depth -= take;
      end
      default: begin
        at = first_with_id(pid);
        if (at >= depth) r.status = STAT_NOT_FOUND;
        else r.pos = at[5:0];
      end
    endcase
    r.occ = depth[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch, result beat %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      depth = 0;
      awaited_outcomes.delete();
      mismatches   = 0;
      results_seen = 0;
      full_rejects = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("no request outstanding, tdata 0x%04h", m_tdata_i));
        end else begin
          want = awaited_outcomes.pop_front();
          if (m_tdata_i[1:0] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_tdata_i[1:0], want.status));
          if (m_tdata_i[7:2] !== want.pos)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      m_tdata_i[7:2], want.pos));
          if (m_tdata_i[14:8] !== want.occ)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      m_tdata_i[14:8], want.occ));
        end
        results_seen++;
      end
      if (s_tvalid_i && s_tready_i) begin
        want = apply_request(srq_op_e'(s_tuser_i), s_tdata_i[7:0], s_tdata_i[39:8],
                             s_tdata_i[46:40]);
        if (want.status == STAT_FULL) full_rejects++;
        awaited_outcomes.push_back(want);
      end
    end
    mismatches_o   <= mismatches;
    outstanding_o  <= awaited_outcomes.size();
    full_rejects_o <= full_rejects;
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench top for the sorted request queue: clock, reset, request stimulus
// and result back-pressure over four handshake phases, plus the verdict.
// Depends on srq_pkg, sorted_request_queue_top and srq_checker.
`default_nettype none

module tb;
  import srq_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 325;
  localparam int unsigned MODE_ITEMS  = 120;

  typedef enum int {
    MODE_FILL,
    MODE_MIXED,
    MODE_DRAIN
  } load_mode_e;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [1:0]             s_axis_tuser_i  = OP_INSERT;
  logic                   m_axis_tready_i = 1'b0;
  wire logic              s_axis_tready_o;
  wire logic              m_axis_tvalid_o;
  wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  int          mismatches;
  int          outstanding;
  int          full_rejects;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned cycles    = 0;
  int          sent_by_op [4];

  sorted_request_queue_top #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (8)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  srq_checker #(
    .CAPACITY (CAPACITY)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid_i),
    .s_tready_i     (s_axis_tready_o),
    .s_tdata_i      (s_axis_tdata_i),
    .s_tuser_i      (s_axis_tuser_i),
    .m_tvalid_i     (m_axis_tvalid_o),
    .m_tready_i     (m_axis_tready_i),
    .m_tdata_i      (m_axis_tdata_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .full_rejects_o (full_rejects)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one request beat and returns at the edge that takes it.
  task automatic send_request(input srq_op_e op, input logic [7:0] pid,
                              input logic [31:0] prio, input logic [6:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, cnt, prio, pid};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_by_op[op]++;
  endtask

  task automatic send_random_request(input load_mode_e mode);
    int          pick;
    srq_op_e     op;
    logic [7:0]  pid;
    logic [31:0] prio;
    logic [6:0]  cnt;
    pick = $urandom_range(99);
    case (mode)
      MODE_FILL:  op = (pick < 80) ? OP_INSERT : (pick < 90) ? OP_FIND :
                       (pick < 98) ? OP_REMOVE : OP_POP;
      MODE_MIXED: op = (pick < 40) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
                       (pick < 90) ? OP_FIND : OP_POP;
      default:    op = (pick < 15) ? OP_INSERT : (pick < 50) ? OP_REMOVE :
                       (pick < 70) ? OP_FIND : OP_POP;
    endcase
    pid = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 40) prio = $urandom_range(7);
    else if (pick < 80) prio = $urandom();
    else if (pick < 87) prio = 32'h0;
    else if (pick < 94) prio = 32'hFFFF_FFFF;
    else prio = 32'h8000_0000;
    pick = $urandom_range(99);
    if (pick < 70) cnt = 7'($urandom_range(4));
    else if (pick < 90) cnt = 7'($urandom_range(64));
    else cnt = ($urandom_range(1) != 0) ? 7'd64 : 7'd63;
    send_request(op, pid, prio, cnt);
  endtask

  initial begin
    int          block;
    int          p;
    int          n;
    load_mode_e  mode;
    for (p = 0; p < 4; p++) sent_by_op[p] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, extremes, ties, duplicates, clamped pops
    send_request(OP_FIND,   8'h05, 32'h0,         7'd0);
    send_request(OP_REMOVE, 8'h00, 32'h0,         7'd0);
    send_request(OP_POP,    8'h00, 32'h0,         7'd0);
    send_request(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 7'd0);
    send_request(OP_INSERT, 8'h00, 32'h0,         7'd0);
    send_request(OP_INSERT, 8'h55, 32'h8000_0000, 7'd0);
    send_request(OP_INSERT, 8'hAA, 32'h8000_0000, 7'd0);
    send_request(OP_INSERT, 8'h55, 32'h8000_0000, 7'd0);
    send_request(OP_INSERT, 8'h10, 32'h8000_0000, 7'd0);
    send_request(OP_FIND,   8'h55, 32'h0,         7'd0);
    send_request(OP_REMOVE, 8'h55, 32'h0,         7'd0);
    send_request(OP_FIND,   8'h55, 32'h0,         7'd0);
    send_request(OP_FIND,   8'hFF, 32'h0,         7'd0);
    send_request(OP_REMOVE, 8'h33, 32'h0,         7'd0);
    send_request(OP_POP,    8'h00, 32'h0,         7'd2);
    send_request(OP_POP,    8'h00, 32'h0,         7'd0);
    send_request(OP_POP,    8'h00, 32'h0,         7'd64);
    send_request(OP_FIND,   8'hAA, 32'h0,         7'd0);
    send_request(OP_INSERT, 8'h01, 32'h0000_0001, 7'd0);
    send_request(OP_INSERT, 8'h02, 32'h0000_0001, 7'd0);
    send_request(OP_POP,    8'h00, 32'h0,         7'd63);

    block = 0;
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 88; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 88; end
        default: begin idle_pct = 20; stall_pct <= 20; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        mode = load_mode_e'((block / MODE_ITEMS) % 3);
        send_random_request(mode);
        block++;
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // the outstanding count is registered, so it lags the last request beat
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (CAPACITY + 16) @(posedge clk_i);

    $display("Sent %0d requests: %0d insert, %0d remove, %0d pop, %0d find;",
             sent_by_op[0] + sent_by_op[1] + sent_by_op[2] + sent_by_op[3],
             sent_by_op[OP_INSERT], sent_by_op[OP_REMOVE], sent_by_op[OP_POP],
             sent_by_op[OP_FIND]);
    $display("%0d inserts rejected on a full queue, four handshake phases.", full_rejects);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
